FILE: src/two_byte_float_codec_defines.svh
// assertion macros for the two-byte float codec
// no dependencies; included by the top level only
`ifndef TWO_BYTE_FLOAT_CODEC_DEFINES_SVH
`define TWO_BYTE_FLOAT_CODEC_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define TBFC_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("tbfc assertion failed");
// next-cycle implication, checked out of reset
`define TBFC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error("tbfc assertion failed");
`else
`define TBFC_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define TBFC_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

FILE: src/tbfc_pkg.sv
// shared types and constants of the two-byte float codec
// no dependencies; used by every module of the codec
package tbfc_pkg;

    localparam int MAG_W   = 32;   // magnitude of the encode input
    localparam int EXP_W   = 5;    // exponent counter, holds up to 31
    localparam int LIM_W   = 12;   // rounded mantissa before packing
    localparam int MANT_W  = 11;   // mantissa field of the code
    localparam int EXPF_W  = 4;    // exponent field of the code
    localparam int CODE_W  = 16;
    localparam int VALUE_W = 27;
    localparam int NORM_STAGES = 5;

    localparam logic [LIM_W-1:0]  POS_LIMIT    = 12'd2047;
    localparam logic [LIM_W-1:0]  NEG_LIMIT    = 12'd2048;
    localparam logic [EXP_W-1:0]  MAX_EXP      = 5'd15;
    localparam logic [CODE_W-1:0] INVALID_CODE = 16'h7FFF;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    // payload that travels down the normalize pipeline
    typedef struct packed {
        logic              op;
        logic              neg;
        logic [CODE_W-1:0] code;
        logic [MAG_W-1:0]  mag;
        logic              rnd;
        logic [EXP_W-1:0]  ex;
    } norm_t;

endpackage

FILE: src/two_byte_float_codec.sv
// Two-byte float codec: encode a 32-bit value in hundredths, or decode a code.
// Path: input register, five normalize steps (shift 16, 8, 4, 2, 1) and the
// output register; done rises when the beat reaches the output register and
// the beat is taken with it.
// Throughput: one beat per cycle, busy stays low after reset.
// Reset: rst_n clears all valid bits and holds busy high until the first edge.
`include "two_byte_float_codec_defines.svh"
module two_byte_float_codec (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                op,
    input  logic signed [tbfc_pkg::MAG_W-1:0]   value_in,
    input  logic [tbfc_pkg::CODE_W-1:0]         code_in,
    output logic                                done,
    output logic [tbfc_pkg::CODE_W-1:0]         code_out,
    output logic signed [tbfc_pkg::VALUE_W-1:0] value_out,
    output logic                                error
);
    import tbfc_pkg::*;

    logic             busy_reg;
    logic             accept;
    logic [MAG_W-1:0] vin_bits;
    logic             vin_neg;
    norm_t            in_next;
    norm_t            in_reg;
    logic             in_valid_reg;

    logic  stage_valid [0:NORM_STAGES];
    norm_t stage_data  [0:NORM_STAGES];

    // busy only right after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b1;
        else
            busy_reg <= 1'b0;
    end

    assign busy   = busy_reg;
    assign accept = start && !busy_reg;

    // input stage: magnitude of the encode value
    assign vin_bits = value_in;
    assign vin_neg  = vin_bits[MAG_W-1];

    always_comb
    begin
        in_next.op   = op;
        in_next.neg  = vin_neg;
        in_next.code = code_in;
        in_next.mag  = vin_neg ? (~vin_bits + {{(MAG_W-1){1'b0}}, 1'b1}) : vin_bits;
        in_next.rnd  = 1'b0;
        in_next.ex   = {EXP_W{1'b0}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_reg <= in_next;
    end

    assign stage_valid[0] = in_valid_reg;
    assign stage_data[0]  = in_reg;

    // normalize pipeline, largest shift first
    genvar i;
    generate
        for (i = 0; i < NORM_STAGES; i++)
        begin : g_norm
            tbfc_norm_stage #(
                .STEP (1 << (NORM_STAGES - 1 - i))
            ) u_norm (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (stage_valid[i]),
                .in_data   (stage_data[i]),
                .out_valid (stage_valid[i+1]),
                .out_data  (stage_data[i+1])
            );
        end
    endgenerate

    // pack and output register
    tbfc_pack u_pack (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stage_valid[NORM_STAGES]),
        .in_data   (stage_data[NORM_STAGES]),
        .done      (done),
        .code_out  (code_out),
        .value_out (value_out),
        .error     (error)
    );

    // checks
    `TBFC_ASSERT_IMPL(a_beat_out, clk, rst_n, accept, ##7 done)
    `TBFC_ASSERT_IMPL(a_no_spurious, clk, rst_n, done, $past(accept, 7))
    `TBFC_ASSERT_IMPL(a_one_zero, clk, rst_n, done, (code_out == 16'h0000 || value_out == 27'sd0))
    `TBFC_ASSERT_IMPL(a_err_form, clk, rst_n, done && error, (value_out == 27'sd0 && (code_out == INVALID_CODE || code_out == 16'h0000)))

endmodule

FILE: src/tbfc_norm_stage.sv
// one binary-search step of the encode normalization: tries a shift of STEP
// depends on tbfc_pkg
module tbfc_norm_stage #(
    parameter int STEP = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  tbfc_pkg::norm_t in_data,
    output logic            out_valid,
    output tbfc_pkg::norm_t out_data
);
    import tbfc_pkg::*;

    logic [MAG_W-1:0] probe;
    logic             rbit;
    logic [MAG_W:0]   rounded;
    logic [MAG_W:0]   lim;
    logic             go;
    norm_t            data_next;
    norm_t            data_reg;
    logic             valid_reg;

    // round bit of the trial shift by STEP-1
    generate
        if (STEP > 1)
        begin : g_rbit_mag
            assign rbit = in_data.mag[STEP-2];
        end
        else
        begin : g_rbit_carry
            assign rbit = in_data.rnd;
        end
    endgenerate

    // rounded value after STEP-1 more shifts still above the limit?
    assign probe   = in_data.mag >> (STEP - 1);
    assign rounded = {1'b0, probe} + {{MAG_W{1'b0}}, rbit};
    assign lim     = in_data.neg ? {{(MAG_W+1-LIM_W){1'b0}}, NEG_LIMIT}
                                 : {{(MAG_W+1-LIM_W){1'b0}}, POS_LIMIT};
    assign go      = rounded > lim;

    // take the full shift when needed
    always_comb
    begin
        data_next = in_data;
        if (go)
        begin
            data_next.mag = in_data.mag >> STEP;
            data_next.rnd = in_data.mag[STEP-1];
            data_next.ex  = in_data.ex + EXP_W'(STEP);
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: src/tbfc_pack.sv
// final stage: rounding, negation and packing for encode, shift for decode
// depends on tbfc_pkg
module tbfc_pack (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  tbfc_pkg::norm_t                     in_data,
    output logic                                done,
    output logic [tbfc_pkg::CODE_W-1:0]         code_out,
    output logic signed [tbfc_pkg::VALUE_W-1:0] value_out,
    output logic                                error
);
    import tbfc_pkg::*;

    logic [LIM_W-1:0]   mant;
    logic [LIM_W-1:0]   neg_mant;
    logic [MANT_W-1:0]  field;
    logic               ovf;
    logic               invalid;
    logic [VALUE_W-1:0] dext;
    logic [VALUE_W-1:0] dval;

    logic [CODE_W-1:0]  code_next;
    logic [VALUE_W-1:0] value_next;
    logic               error_next;

    logic               done_reg;
    logic [CODE_W-1:0]  code_reg;
    logic [VALUE_W-1:0] value_reg;
    logic               error_reg;

    // encode: add the round bit, negatives store 2048 minus mantissa
    assign mant     = in_data.mag[LIM_W-1:0] + {{(LIM_W-1){1'b0}}, in_data.rnd};
    assign neg_mant = {LIM_W{1'b0}} - mant;
    assign field    = in_data.neg ? neg_mant[MANT_W-1:0] : mant[MANT_W-1:0];
    assign ovf      = in_data.ex > MAX_EXP;

    // decode: sign bit weighs -2048, then shift by the exponent
    assign invalid = in_data.code == INVALID_CODE;
    assign dext    = {{(VALUE_W-MANT_W-1){in_data.code[CODE_W-1]}},
                      in_data.code[CODE_W-1], in_data.code[MANT_W-1:0]};
    assign dval    = dext << in_data.code[CODE_W-2 -: EXPF_W];

    // select the result of the operation
    always_comb
    begin
        code_next  = {CODE_W{1'b0}};
        value_next = {VALUE_W{1'b0}};
        error_next = 1'b0;
        case (in_data.op)
            OP_ENCODE:
            begin
                error_next = ovf;
                code_next  = ovf ? INVALID_CODE
                                 : {in_data.neg, in_data.ex[EXPF_W-1:0], field};
            end
            OP_DECODE:
            begin
                error_next = invalid;
                value_next = invalid ? {VALUE_W{1'b0}} : dval;
            end
            default:
            begin
                error_next = 1'b0;
            end
        endcase
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= in_valid;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            code_reg  <= code_next;
            value_reg <= value_next;
            error_reg <= error_next;
        end
    end

    assign done      = done_reg;
    assign code_out  = code_reg;
    assign value_out = signed'(value_reg);
    assign error     = error_reg;

endmodule
